@@ hw/rtl/lspe_pkg.sv @@
// Shared types and constants for the LSB payload extractor.
// Used by the front, queue, back and top-level modules; depends on nothing.

package lspe_pkg;

   localparam int unsigned MARKER_LENGTH = 6;
   localparam int unsigned HOLD_DEPTH    = MARKER_LENGTH - 1;

   localparam logic [1:0] BYTE_SEC_KEY     = 2'd0;
   localparam logic [1:0] BYTE_SEC_MESSAGE = 2'd3;
   localparam logic [2:0] RSP_SEC_END      = 3'd4;

   typedef struct packed {
      logic [7:0] channel_value;
      logic       start_of_image;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [2:0] section;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] section;
      logic       restart;
   } byte_item_type;

   // Terminator "xyzXYZ", one character per matcher stage.
   function automatic logic [7:0] marker_char(input logic [2:0] stage);
      logic [7:0] ch;
      unique case (stage)
         3'd0:    ch = 8'd120;
         3'd1:    ch = 8'd121;
         3'd2:    ch = 8'd122;
         3'd3:    ch = 8'd88;
         3'd4:    ch = 8'd89;
         3'd5:    ch = 8'd90;
         default: ch = 8'd0;
      endcase
      return ch;
   endfunction

endpackage

@@ hw/rtl/lspe_front.sv @@
// Front end: collects sample LSBs into bytes and labels each byte's section.
// Depends on lspe_pkg; feeds byte transfers into lspe_queue.

module lspe_front #(
   parameter int unsigned SECTION_BYTES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  lspe_pkg::req_payload_type req_payload,
   input  logic                     queue_full,
   output logic                     req_stall,
   output logic                     push,
   output lspe_pkg::byte_item_type  push_item
);

   logic [2:0] bit_pos_ff,  bit_pos_in;
   logic [7:0] partial_ff,  partial_in;
   logic [1:0] section_ff,  section_in;
   logic [3:0] count_ff,    count_in;
   logic       pending_ff,  pending_in;

   logic       accept;
   logic       start;
   logic [2:0] eff_pos;
   logic [7:0] eff_partial;
   logic [1:0] eff_section;
   logic [3:0] eff_count;
   logic [7:0] new_partial;
   logic       byte_done;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign start     = req_payload.start_of_image;

   always_comb begin
      eff_pos     = start ? 3'd0 : bit_pos_ff;
      eff_partial = start ? 8'd0 : partial_ff;
      eff_section = start ? lspe_pkg::BYTE_SEC_KEY : section_ff;
      eff_count   = start ? 4'd0 : count_ff;
      new_partial = {eff_partial[6:0], req_payload.channel_value[0]};
      byte_done   = (eff_pos == 3'd7);

      bit_pos_in  = bit_pos_ff;
      partial_in  = partial_ff;
      section_in  = section_ff;
      count_in    = count_ff;
      pending_in  = pending_ff;

      if (accept) begin
         bit_pos_in = eff_pos + 3'd1;
         partial_in = new_partial;
         section_in = eff_section;
         count_in   = eff_count;
         pending_in = byte_done ? 1'b0 : (start || pending_ff);
         if (byte_done && (eff_section != lspe_pkg::BYTE_SEC_MESSAGE)) begin
            if (eff_count == 4'(SECTION_BYTES - 1)) begin
               count_in   = 4'd0;
               section_in = eff_section + 2'd1;
            end else begin
               count_in = eff_count + 4'd1;
            end
         end
      end

      push              = accept && byte_done;
      push_item.data    = new_partial;
      push_item.section = eff_section;
      push_item.restart = start || pending_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_pos_ff <= 3'd0;
         partial_ff <= 8'd0;
         section_ff <= lspe_pkg::BYTE_SEC_KEY;
         count_ff   <= 4'd0;
         pending_ff <= 1'b0;
      end else begin
         bit_pos_ff <= bit_pos_in;
         partial_ff <= partial_in;
         section_ff <= section_in;
         count_ff   <= count_in;
         pending_ff <= pending_in;
      end
   end

endmodule

@@ hw/rtl/lspe_queue.sv @@
// Two-entry queue of byte transfers between the front and back ends.
// Depends on lspe_pkg for the byte item type.

module lspe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lspe_pkg::byte_item_type push_item,
   output logic                    full,
   output logic                    item_valid,
   output lspe_pkg::byte_item_type item,
   input  logic                    pop
);

   lspe_pkg::byte_item_type entries [2];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/lspe_back.sv @@
// Back end: terminator matcher, message hold line and result register.
// Depends on lspe_pkg; takes byte transfers from lspe_queue.

module lspe_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  lspe_pkg::byte_item_type  item,
   output logic                     pop,
   output logic                     rsp_valid,
   output lspe_pkg::rsp_payload_type rsp_payload,
   input  logic                     rsp_stall
);

   logic [7:0] hold_ff [lspe_pkg::HOLD_DEPTH];

   logic [2:0] stage_ff, stage_in;
   logic [2:0] fill_ff,  fill_in;
   logic       done_ff,  done_in;
   logic       rsp_valid_ff, rsp_valid_in;
   lspe_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic       load_ok;
   logic [2:0] eff_stage;
   logic [2:0] eff_fill;
   logic       eff_done;
   logic       emit;
   logic       hold_write;
   logic       hold_shift;

   assign load_ok     = !rsp_valid_ff || !rsp_stall;
   assign pop         = item_valid && load_ok;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_comb begin
      eff_stage = item.restart ? 3'd0 : stage_ff;
      eff_fill  = item.restart ? 3'd0 : fill_ff;
      eff_done  = item.restart ? 1'b0 : done_ff;

      stage_in       = stage_ff;
      fill_in        = fill_ff;
      done_in        = done_ff;
      emit           = 1'b0;
      hold_write     = 1'b0;
      hold_shift     = 1'b0;
      rsp_payload_in = rsp_payload_ff;

      if (pop) begin
         stage_in = eff_stage;
         fill_in  = eff_fill;
         done_in  = eff_done;
         if (item.section != lspe_pkg::BYTE_SEC_MESSAGE) begin
            emit                     = 1'b1;
            rsp_payload_in.data_byte = item.data;
            rsp_payload_in.section   = {1'b0, item.section};
            rsp_payload_in.last      = 1'b0;
         end else if (!eff_done) begin
            if (eff_stage == 3'(lspe_pkg::MARKER_LENGTH - 1) &&
                item.data == lspe_pkg::marker_char(eff_stage)) begin
               done_in                  = 1'b1;
               fill_in                  = 3'd0;
               stage_in                 = 3'd0;
               emit                     = 1'b1;
               rsp_payload_in.data_byte = 8'd0;
               rsp_payload_in.section   = lspe_pkg::RSP_SEC_END;
               rsp_payload_in.last      = 1'b1;
            end else begin
               if (eff_stage != 3'(lspe_pkg::MARKER_LENGTH - 1) &&
                   item.data == lspe_pkg::marker_char(eff_stage)) begin
                  stage_in = eff_stage + 3'd1;
               end else begin
                  stage_in = 3'd0;
               end
               if (eff_fill != 3'(lspe_pkg::HOLD_DEPTH)) begin
                  hold_write = 1'b1;
                  fill_in    = eff_fill + 3'd1;
               end else begin
                  hold_shift               = 1'b1;
                  emit                     = 1'b1;
                  rsp_payload_in.data_byte = hold_ff[0];
                  rsp_payload_in.section   = {1'b0, lspe_pkg::BYTE_SEC_MESSAGE};
                  rsp_payload_in.last      = 1'b0;
               end
            end
         end
      end

      rsp_valid_in = load_ok ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (hold_shift) begin
         for (int i = 0; i < lspe_pkg::HOLD_DEPTH - 1; i++) begin
            hold_ff[i] <= hold_ff[i + 1];
         end
         hold_ff[lspe_pkg::HOLD_DEPTH - 1] <= item.data;
      end else if (hold_write) begin
         hold_ff[eff_fill] <= item.data;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         stage_ff     <= 3'd0;
         fill_ff      <= 3'd0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_ff     <= stage_in;
         fill_ff      <= fill_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/lsb_stego_payload_extractor_top.sv @@
// Top level of the LSB payload extractor; instantiates lspe_front, lspe_queue
// and lspe_back and uses the types of lspe_pkg.
// Throughput: one sample per cycle while req_stall is low; at most one result per eight samples.
// Path: a result for the sample that completes its byte is written into a queue entry
// and then into the result register; message bytes leave five bytes late.
// Synchronous active-high reset clears all control state; no clearing pass.

module lsb_stego_payload_extractor_top #(
   parameter int unsigned SECTION_BYTES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  lspe_pkg::req_payload_type req_payload,
   output logic                      req_stall,
   output logic                      rsp_valid,
   output lspe_pkg::rsp_payload_type rsp_payload,
   input  logic                      rsp_stall
);

   logic                    push;
   lspe_pkg::byte_item_type push_item;
   logic                    queue_full;
   logic                    item_valid;
   lspe_pkg::byte_item_type item;
   logic                    pop;

   lspe_front #(
      .SECTION_BYTES(SECTION_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_payload(req_payload),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_item  (push_item)
   );

   lspe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .item_valid(item_valid),
      .item      (item),
      .pop       (pop)
   );

   lspe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .rsp_stall  (rsp_stall)
   );

endmodule
